FILE: rtl/erfa_pkg.sv
// shared constants, types and elaboration-time coefficient functions for the erf unit
`timescale 1ns / 1ps
package erfa_pkg;

    typedef logic [63:0]  t_q62;
    typedef logic [127:0] t_wide;

    localparam int DEN_W      = 51;
    localparam int QUO_W      = 63;
    localparam int B_W        = 29;
    localparam int N_W        = 5;
    localparam int DIV_STEPS  = 62;
    localparam int POLY_CELLS = 5;
    localparam int EXP_TERMS  = 22;
    localparam int POW_CELLS  = 16;

    localparam logic [31:0]      FOUR_Q26 = 32'h1000_0000;
    localparam logic [31:0]      ONE_Q30  = 32'h4000_0000;
    localparam t_q62             ONE_Q62  = 64'h4000_0000_0000_0000;
    localparam t_q62             HALF_Q31 = 64'h0000_0000_8000_0000;
    localparam t_wide            RND_Q62  = 128'd1 << 61;
    localparam logic [DEN_W-1:0] DEN_N    = 51'd671088640000000;
    localparam logic [21:0]      P_NUM    = 22'd3275911;
    localparam t_q62             COEF_DEN = 64'd1000000000;

    function automatic t_wide f_udiv(input t_wide num, input t_wide den);
        t_wide q;
        t_wide r;
        q = '0;
        r = '0;
        for (int i = 127; i >= 0; i--) begin
            r = {r[126:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_q62 f_mul_q62(input t_q62 a, input t_q62 b);
        t_wide p;
        p = {64'd0, a} * {64'd0, b};
        p = p + RND_Q62;
        return p[125:62];
    endfunction

    function automatic t_q62 f_ratio(input t_q62 num, input t_q62 den);
        t_wide nn;
        t_wide dd;
        t_wide q;
        t_wide rem;
        nn  = {64'd0, num} << 62;
        dd  = {64'd0, den};
        q   = f_udiv(nn, dd);
        rem = nn - q * dd;
        if (rem >= dd - rem) begin
            q = q + 128'd1;
        end
        return q[63:0];
    endfunction

    function automatic t_q62 f_exp_neg(input t_q62 v);
        t_q62  term;
        t_q62  sum;
        t_wide tmp;
        term = ONE_Q62;
        sum  = ONE_Q62;
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = f_mul_q62(term, v);
            tmp  = f_udiv({64'd0, term} + 128'(k >> 1), 128'(k));
            term = tmp[63:0];
            if ((k & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum[63]) begin
            sum = '0;
        end
        return sum;
    endfunction

    localparam t_q62 A1 = f_ratio(64'd254829592, COEF_DEN);
    localparam t_q62 A2 = f_ratio(64'd284496736, COEF_DEN);
    localparam t_q62 A3 = f_ratio(64'd1421413741, COEF_DEN);
    localparam t_q62 A4 = f_ratio(64'd1453152027, COEF_DEN);
    localparam t_q62 A5 = f_ratio(64'd1061405429, COEF_DEN);
    localparam t_q62 E1 = f_exp_neg(ONE_Q62);

endpackage

FILE: rtl/erfa_div_cell.sv
// one restoring step of the reciprocal divider
`timescale 1ns / 1ps
module erfa_div_cell import erfa_pkg::*; #(
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [DEN_W-1:0] i_r,
    input  logic [QUO_W-1:0] i_q,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SW-1:0]    i_side,
    output logic             o_vld,
    output logic [DEN_W-1:0] o_r,
    output logic [QUO_W-1:0] o_q,
    output logic [DEN_W-1:0] o_den,
    output logic [SW-1:0]    o_side
);

    logic             r_vld;
    logic [DEN_W-1:0] r_r;
    logic [QUO_W-1:0] r_q;
    logic [DEN_W-1:0] r_den;
    logic [SW-1:0]    r_side;
    logic [DEN_W:0]   r2;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_r;
    logic [QUO_W-1:0] n_q;

    always_comb begin
        r2   = {i_r, 1'b0};
        ge   = r2 >= {1'b0, i_den};
        diff = r2 - {1'b0, i_den};
        n_r  = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
        n_q  = {i_q[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r    <= n_r;
            r_q    <= n_q;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_r    = r_r;
    assign o_q    = r_q;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

FILE: rtl/erfa_mul.sv
// two-stage 64 by 64 multiplier from four 32 by 32 partial products
`timescale 1ns / 1ps
module erfa_mul import erfa_pkg::*; #(
    parameter int    SW  = 1,
    parameter t_wide RND = '0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  t_q62          i_a,
    input  t_q62          i_b,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output t_wide         o_prod,
    output logic [SW-1:0] o_side
);

    logic          r_vld1;
    logic          r_vld2;
    logic [63:0]   r_p00;
    logic [63:0]   r_p01;
    logic [63:0]   r_p10;
    logic [63:0]   r_p11;
    logic [SW-1:0] r_side1;
    logic [SW-1:0] r_side2;
    t_wide         r_prod;
    logic [63:0]   n_p00;
    logic [63:0]   n_p01;
    logic [63:0]   n_p10;
    logic [63:0]   n_p11;
    t_wide         n_prod;

    always_comb begin
        n_p00  = {32'd0, i_a[31:0]} * {32'd0, i_b[31:0]};
        n_p01  = {32'd0, i_a[31:0]} * {32'd0, i_b[63:32]};
        n_p10  = {32'd0, i_a[63:32]} * {32'd0, i_b[31:0]};
        n_p11  = {32'd0, i_a[63:32]} * {32'd0, i_b[63:32]};
        n_prod = {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
               + {r_p11, 64'd0} + RND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00   <= n_p00;
            r_p01   <= n_p01;
            r_p10   <= n_p10;
            r_p11   <= n_p11;
            r_side1 <= i_side;
            r_prod  <= n_prod;
            r_side2 <= r_side1;
        end
    end

    assign o_vld  = r_vld2;
    assign o_prod = r_prod;
    assign o_side = r_side2;

endmodule

FILE: rtl/erfa_poly_cell.sv
// horner cell of the rational polynomial: h = round(h * t) + coefficient
`timescale 1ns / 1ps
module erfa_poly_cell import erfa_pkg::*; #(
    parameter int   SW   = 1,
    parameter t_q62 COEF = '0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  t_q62          i_h,
    input  t_q62          i_t,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output t_q62          o_h,
    output t_q62          o_t,
    output logic [SW-1:0] o_side
);

    localparam int MW = SW + 65;

    logic          r_vld_a;
    t_q62          r_mag;
    logic          r_neg;
    t_q62          r_t;
    logic [SW-1:0] r_side_a;
    logic          m_vld;
    t_wide         m_prod;
    logic [MW-1:0] m_side;
    logic          m_neg;
    t_q62          m_t;
    logic [SW-1:0] m_sd;
    t_q62          m_val;
    logic          r_vld_d;
    t_q62          r_h;
    t_q62          r_t_d;
    logic [SW-1:0] r_side_d;
    t_q62          n_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_d <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_d <= m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag    <= i_h[63] ? (64'd0 - i_h) : i_h;
            r_neg    <= i_h[63];
            r_t      <= i_t;
            r_side_a <= i_side;
            r_h      <= n_h;
            r_t_d    <= m_t;
            r_side_d <= m_sd;
        end
    end

    erfa_mul #(.SW(MW), .RND(RND_Q62)) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (r_vld_a),
        .i_a    (r_mag),
        .i_b    (r_t),
        .i_side ({r_neg, r_t, r_side_a}),
        .o_vld  (m_vld),
        .o_prod (m_prod),
        .o_side (m_side)
    );

    always_comb begin
        {m_neg, m_t, m_sd} = m_side;
        m_val = m_prod[125:62];
        n_h   = (m_neg ? (64'd0 - m_val) : m_val) + COEF;
    end

    assign o_vld  = r_vld_d;
    assign o_h    = r_h;
    assign o_t    = r_t_d;
    assign o_side = r_side_d;

endmodule

FILE: rtl/erfa_exp_cell.sv
// one term of the exp(-v) series: term = round(round(term * v) / k), sum += or -= term
`timescale 1ns / 1ps
module erfa_exp_cell import erfa_pkg::*; #(
    parameter int SW = 1,
    parameter int K  = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  t_q62          i_term,
    input  t_q62          i_sum,
    input  t_q62          i_v,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output t_q62          o_term,
    output t_q62          o_sum,
    output t_q62          o_v,
    output logic [SW-1:0] o_side
);

    localparam t_q62 RECIP  = 64'hFFFF_FFFF_FFFF_FFFF / 64'(K);
    localparam t_q62 HALF_K = 64'(K / 2);
    localparam t_q62 K_VAL  = 64'(K);
    localparam bit   ODD    = (K % 2) == 1;
    localparam int   W1     = SW + 128;
    localparam int   W2     = SW + 192;

    logic          m1_vld;
    t_wide         m1_prod;
    logic [W1-1:0] m1_side;
    logic          r_vld_c;
    t_q62          r_x;
    logic [W1-1:0] r_side_c;
    logic          m2_vld;
    t_wide         m2_prod;
    logic [W2-1:0] m2_side;
    logic          r_vld_f;
    t_q62          r_q0;
    t_q62          r_qk;
    t_q62          r_x_f;
    logic [W1-1:0] r_side_f;
    logic          r_vld_g;
    t_q62          r_term_g;
    logic [W1-1:0] r_side_g;
    logic          r_vld_h;
    t_q62          r_term;
    t_q62          r_sum;
    t_q62          r_v;
    logic [SW-1:0] r_side;
    t_q62          rem;
    t_q62          n_term;
    t_q62          g_v;
    t_q62          g_sum;
    logic [SW-1:0] g_sd;
    t_q62          n_sum;

    erfa_mul #(.SW(W1), .RND(RND_Q62)) u_mul_tv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (i_vld),
        .i_a    (i_term),
        .i_b    (i_v),
        .i_side ({i_v, i_sum, i_side}),
        .o_vld  (m1_vld),
        .o_prod (m1_prod),
        .o_side (m1_side)
    );

    erfa_mul #(.SW(W2), .RND('0)) u_mul_rk (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (i_en),
        .i_vld  (r_vld_c),
        .i_a    (r_x),
        .i_b    (RECIP),
        .i_side ({r_x, r_side_c}),
        .o_vld  (m2_vld),
        .o_prod (m2_prod),
        .o_side (m2_side)
    );

    always_comb begin
        rem    = r_x_f - r_qk;
        n_term = (rem >= K_VAL) ? (r_q0 + 64'd1) : r_q0;
        {g_v, g_sum, g_sd} = r_side_g;
        n_sum  = ODD ? (g_sum - r_term_g) : (g_sum + r_term_g);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_f <= 1'b0;
            r_vld_g <= 1'b0;
            r_vld_h <= 1'b0;
        end else if (i_en) begin
            r_vld_c <= m1_vld;
            r_vld_f <= m2_vld;
            r_vld_g <= r_vld_f;
            r_vld_h <= r_vld_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x      <= m1_prod[125:62] + HALF_K;
            r_side_c <= m1_side;
            r_q0     <= m2_prod[127:64];
            r_qk     <= m2_prod[127:64] * K_VAL;
            r_x_f    <= m2_side[W2-1:W1];
            r_side_f <= m2_side[W1-1:0];
            r_term_g <= n_term;
            r_side_g <= r_side_f;
            r_term   <= r_term_g;
            r_sum    <= n_sum;
            r_v      <= g_v;
            r_side   <= g_sd;
        end
    end

    assign o_vld  = r_vld_h;
    assign o_term = r_term;
    assign o_sum  = r_sum;
    assign o_v    = r_v;
    assign o_side = r_side;

endmodule

FILE: rtl/error_function_approx_unit.sv
// top level of the pipelined erf unit, Q5.26 argument in, Q1.30 result out
// Accepts one word per clock and returns one word per argument, in order. The pipeline
// is a chain of cells: a 62-cell restoring divider for t, five Horner cells of four
// stages, 22 exp series cells of eight stages and sixteen conditional exp(-1)
// multiply cells of two stages. The whole chain holds when a finished word waits at
// the output. Arguments with magnitude above 4.0 return exactly plus or minus 1.0
// with o_clipped set.
`timescale 1ns / 1ps
module error_function_approx_unit import erfa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_x_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_erf_value,
    output logic               o_clipped
);

    localparam int DSW = B_W + 2;
    localparam int PSW = N_W + 64 + 2;
    localparam int ESW = 64 + N_W + 2;
    localparam int WSW = 64 + N_W + 64 + 2;

    logic en;

    // front: magnitude and clip
    logic           r0_vld;
    logic           r0_neg;
    logic           r0_clip;
    logic [B_W-1:0] r0_b;
    logic [31:0]    mag32;
    logic           clip0;

    // divider
    logic             r1_vld;
    logic [DEN_W-1:0] r1_den;
    logic [DEN_W-1:0] r1_r;
    logic [QUO_W-1:0] r1_q;
    logic [DSW-1:0]   r1_side;
    logic             dv_vld  [0:DIV_STEPS];
    logic [DEN_W-1:0] dv_r    [0:DIV_STEPS];
    logic [QUO_W-1:0] dv_q    [0:DIV_STEPS];
    logic [DEN_W-1:0] dv_den  [0:DIV_STEPS];
    logic [DSW-1:0]   dv_side [0:DIV_STEPS];

    // rounding of t and split of b squared
    logic           rt_neg;
    logic           rt_clip;
    logic [B_W-1:0] rt_b;
    logic [57:0]    y_sq;
    logic           r2_vld;
    t_q62           r2_t;
    logic [PSW-1:0] r2_side;

    // polynomial
    logic           pl_vld  [0:POLY_CELLS];
    t_q62           pl_h    [0:POLY_CELLS];
    t_q62           pl_t    [0:POLY_CELLS];
    logic [PSW-1:0] pl_side [0:POLY_CELLS];
    logic [N_W-1:0] pe_n;
    t_q62           pe_f;
    logic           pe_neg;
    logic           pe_clip;
    t_q62           p_pos;

    // exp series
    logic           ex_vld  [0:EXP_TERMS];
    t_q62           ex_term [0:EXP_TERMS];
    t_q62           ex_sum  [0:EXP_TERMS];
    t_q62           ex_v    [0:EXP_TERMS];
    logic [ESW-1:0] ex_side [0:EXP_TERMS];
    t_q62           c_pos;

    // powers of exp(-1)
    logic           pw_vld  [0:POW_CELLS];
    t_q62           pw_c    [0:POW_CELLS];
    logic [ESW-1:0] pw_rest [0:POW_CELLS];
    t_wide          pw_prod [0:POW_CELLS-1];
    logic [WSW-1:0] pw_oside[0:POW_CELLS-1];

    // p times c and output
    t_q62           pq_p;
    logic [N_W-1:0] pq_n;
    logic           pq_neg;
    logic           pq_clip;
    logic           pc_vld;
    t_wide          pc_prod;
    logic [1:0]     pc_side;
    t_q62           pc_val;
    logic           r3_vld;
    t_q62           r3_res;
    logic           r3_neg;
    logic           r3_clip;
    t_q62           rnd_res;
    logic [31:0]    mag_t;
    logic [31:0]    mag_s;
    logic           r4_vld;
    logic [31:0]    r4_out;
    logic           r4_clip;

    function automatic t_q62 pl_coef_const(input int idx);
        t_q62 c;
        case (idx)
            0:       c = 64'd0 - A4;
            1:       c = A3;
            2:       c = 64'd0 - A2;
            3:       c = A1;
            default: c = 64'd0;
        endcase
        return c;
    endfunction

    assign en      = !r4_vld || i_ready;
    assign o_ready = en;

    always_comb begin
        mag32 = i_x_value[31] ? (32'd0 - i_x_value) : i_x_value;
        clip0 = mag32 > FOUR_Q26;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
            r1_vld <= r0_vld;
            r2_vld <= dv_vld[DIV_STEPS];
            r3_vld <= pc_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_neg  <= i_x_value[31];
            r0_clip <= clip0;
            r0_b    <= clip0 ? '0 : mag32[B_W-1:0];
            r1_den  <= DEN_N + DEN_W'(P_NUM) * DEN_W'(r0_b);
            r1_r    <= (r0_b == '0) ? '0 : DEN_N;
            r1_q    <= QUO_W'(r0_b == '0);
            r1_side <= {r0_neg, r0_clip, r0_b};
        end
    end

    assign dv_vld[0]  = r1_vld;
    assign dv_r[0]    = r1_r;
    assign dv_q[0]    = r1_q;
    assign dv_den[0]  = r1_den;
    assign dv_side[0] = r1_side;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        erfa_div_cell #(.SW(DSW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (dv_vld[i]),
            .i_r    (dv_r[i]),
            .i_q    (dv_q[i]),
            .i_den  (dv_den[i]),
            .i_side (dv_side[i]),
            .o_vld  (dv_vld[i+1]),
            .o_r    (dv_r[i+1]),
            .o_q    (dv_q[i+1]),
            .o_den  (dv_den[i+1]),
            .o_side (dv_side[i+1])
        );
    end

    always_comb begin
        {rt_neg, rt_clip, rt_b} = dv_side[DIV_STEPS];
        y_sq = 58'(rt_b) * 58'(rt_b);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t    <= ({dv_r[DIV_STEPS], 1'b0} >= {1'b0, dv_den[DIV_STEPS]})
                     ? ({1'b0, dv_q[DIV_STEPS]} + 64'd1) : {1'b0, dv_q[DIV_STEPS]};
            r2_side <= {y_sq[56:52], 2'd0, y_sq[51:0], 10'd0, rt_neg, rt_clip};
        end
    end

    assign pl_vld[0]  = r2_vld;
    assign pl_h[0]    = A5;
    assign pl_t[0]    = r2_t;
    assign pl_side[0] = r2_side;

    for (genvar i = 0; i < POLY_CELLS; i++) begin : g_poly
        erfa_poly_cell #(.SW(PSW), .COEF(pl_coef_const(i))) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (pl_vld[i]),
            .i_h    (pl_h[i]),
            .i_t    (pl_t[i]),
            .i_side (pl_side[i]),
            .o_vld  (pl_vld[i+1]),
            .o_h    (pl_h[i+1]),
            .o_t    (pl_t[i+1]),
            .o_side (pl_side[i+1])
        );
    end

    always_comb begin
        {pe_n, pe_f, pe_neg, pe_clip} = pl_side[POLY_CELLS];
        p_pos = pl_h[POLY_CELLS][63] ? 64'd0 : pl_h[POLY_CELLS];
    end

    assign ex_vld[0]  = pl_vld[POLY_CELLS];
    assign ex_term[0] = ONE_Q62;
    assign ex_sum[0]  = ONE_Q62;
    assign ex_v[0]    = pe_f;
    assign ex_side[0] = {p_pos, pe_n, pe_neg, pe_clip};

    for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
        erfa_exp_cell #(.SW(ESW), .K(i + 1)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (ex_vld[i]),
            .i_term (ex_term[i]),
            .i_sum  (ex_sum[i]),
            .i_v    (ex_v[i]),
            .i_side (ex_side[i]),
            .o_vld  (ex_vld[i+1]),
            .o_term (ex_term[i+1]),
            .o_sum  (ex_sum[i+1]),
            .o_v    (ex_v[i+1]),
            .o_side (ex_side[i+1])
        );
    end

    assign c_pos = ex_sum[EXP_TERMS][63] ? 64'd0 : ex_sum[EXP_TERMS];

    assign pw_vld[0]  = ex_vld[EXP_TERMS];
    assign pw_c[0]    = c_pos;
    assign pw_rest[0] = ex_side[EXP_TERMS];

    for (genvar j = 0; j < POW_CELLS; j++) begin : g_pow
        logic [N_W-1:0] n_j;
        erfa_mul #(.SW(WSW), .RND(RND_Q62)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (pw_vld[j]),
            .i_a    (pw_c[j]),
            .i_b    (E1),
            .i_side ({pw_c[j], pw_rest[j]}),
            .o_vld  (pw_vld[j+1]),
            .o_prod (pw_prod[j]),
            .o_side (pw_oside[j])
        );
        assign pw_rest[j+1] = pw_oside[j][ESW-1:0];
        assign n_j          = pw_oside[j][N_W+1:2];
        assign pw_c[j+1]    = (n_j > N_W'(j)) ? pw_prod[j][125:62]
                                              : pw_oside[j][WSW-1:ESW];
    end

    assign {pq_p, pq_n, pq_neg, pq_clip} = pw_rest[POW_CELLS];

    erfa_mul #(.SW(2), .RND(RND_Q62)) u_mul_pc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (pw_vld[POW_CELLS]),
        .i_a    (pq_p),
        .i_b    (pw_c[POW_CELLS]),
        .i_side ({pq_neg, pq_clip}),
        .o_vld  (pc_vld),
        .o_prod (pc_prod),
        .o_side (pc_side)
    );

    always_comb begin
        pc_val  = pc_prod[125:62];
        rnd_res = r3_res + HALF_Q31;
        mag_t   = rnd_res[63:32];
        mag_s   = (r3_clip || (mag_t > ONE_Q30)) ? ONE_Q30 : mag_t;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_res  <= (pc_val >= ONE_Q62) ? 64'd0 : (ONE_Q62 - pc_val);
            r3_neg  <= pc_side[1];
            r3_clip <= pc_side[0];
            r4_out  <= r3_neg ? (32'd0 - mag_s) : mag_s;
            r4_clip <= r3_clip;
        end
    end

    assign o_valid     = r4_vld;
    assign o_erf_value = r4_out;
    assign o_clipped   = r4_clip;

endmodule

FILE: dv/error_function_approx_checker.sv
// checker for the erf unit: bit-exact erf predictor and in-order result comparison
`timescale 1ns / 1ps
module error_function_approx_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic signed [31:0] i_x_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_erf_value,
    input  logic               i_clipped,
    output int                 o_fail_count,
    output int                 o_pending
);
    typedef struct packed {
        logic [31:0] erf_value;
        logic        clipped;
    } t_erf_word;

    t_erf_word erf_expected_q[$];
    int        fail_count = 0;
    int        pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << 61);
        return p[125:62];
    endfunction

    function automatic logic [63:0] q62_div(input logic [63:0] num, input logic [63:0] den);
        logic [127:0] nn;
        logic [127:0] q;
        logic [127:0] r;
        nn = {64'd0, num} << 62;
        q  = nn / {64'd0, den};
        r  = nn - q * {64'd0, den};
        if (r >= {64'd0, den} - r) q = q + 1;
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] q62_smul(input logic signed [63:0] h,
                                                    input logic [63:0] t);
        if (h < 0) return -$signed(q62_mul(-h, t));
        return $signed(q62_mul(h, t));
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] v);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = 64'd1 << 62;
        sum  = 64'sd1 <<< 62;
        for (int k = 1; k <= 22; k++) begin
            term = q62_mul(term, v);
            term = (term + 64'(k / 2)) / 64'(k);
            if (k % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        if (sum < 0) sum = 0;
        return sum;
    endfunction

    function automatic t_erf_word erf_predict(input logic [31:0] x);
        t_erf_word          w;
        logic               neg;
        logic [63:0]        b, t, p, y, n, c, e1, pc, r, mag;
        logic signed [63:0] h;
        neg = x[31];
        b   = neg ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
        w.clipped = 1'b0;
        if (b > 64'h1000_0000) begin
            mag = 64'h4000_0000;
            w.clipped = 1'b1;
        end else begin
            t = q62_div(64'd671088640000000, 64'd671088640000000 + 64'd3275911 * b);
            h = q62_div(64'd1061405429, 64'd1000000000);
            h = q62_smul(h, t) - $signed(q62_div(64'd1453152027, 64'd1000000000));
            h = q62_smul(h, t) + $signed(q62_div(64'd1421413741, 64'd1000000000));
            h = q62_smul(h, t) - $signed(q62_div(64'd284496736, 64'd1000000000));
            h = q62_smul(h, t) + $signed(q62_div(64'd254829592, 64'd1000000000));
            h = q62_smul(h, t);
            p = (h < 0) ? 64'd0 : h;
            y = b * b;
            n = y >> 52;
            c = exp_neg({y[51:0], 10'd0} & 64'h3FFF_FFFF_FFFF_FFFF);
            e1 = exp_neg(64'd1 << 62);
            for (int i = 0; i < n && i < 16; i++) c = q62_mul(c, e1);
            pc  = q62_mul(p, c);
            r   = (pc >= (64'd1 << 62)) ? 64'd0 : (64'd1 << 62) - pc;
            mag = (r + (64'd1 << 31)) >> 32;
            if (mag > 64'h4000_0000) mag = 64'h4000_0000;
        end
        w.erf_value = neg ? 32'((64'd1 << 32) - mag) : mag[31:0];
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_erf_word e;
        if (i_rst_n) begin
            if (i_valid && i_ready_in) erf_expected_q.push_back(erf_predict(i_x_value));
            if (i_out_valid && i_out_ready) begin
                if (erf_expected_q.size() == 0) begin
                    $error("unexpected word: erf_value %0d clipped %0d",
                           i_erf_value, i_clipped);
                    fail_count++;
                end else begin
                    e = erf_expected_q.pop_front();
                    if (e.erf_value !== i_erf_value) begin
                        $error("erf_value expected %0d actual %0d",
                               $signed(e.erf_value), i_erf_value);
                        fail_count++;
                    end
                    if (e.clipped !== i_clipped) begin
                        $error("clipped expected %0d actual %0d", e.clipped, i_clipped);
                        fail_count++;
                    end
                end
            end
            pending_count = erf_expected_q.size();
        end
    end
endmodule

FILE: dv/error_function_approx_unit_test.sv
// testbench top for the erf unit: stimulus, output stalls, watchdog and verdict
`timescale 1ns / 1ps
module error_function_approx_unit_test;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_x_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_erf_value;
    logic               o_clipped;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    int                 out_wait = 0;

    localparam int WATCHDOG_LIMIT = 5000;

    always #10 i_clk = ~i_clk;

    error_function_approx_unit dut (.*);

    error_function_approx_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_x_value(i_x_value), .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_erf_value(o_erf_value), .i_clipped(o_clipped),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [31:0] random_arg();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h1000_0000);
            2: return -$urandom_range(0, 32'h1000_0000);
            3: return 32'h1000_0000 + $urandom_range(0, 64) - 32;
            4: return -(32'h1000_0000 + $urandom_range(0, 64) - 32);
            default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    // starts and ends at a rising edge; valid stays high after acceptance
    task automatic send_word(input logic [31:0] x, input bit no_gap);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_value <= x;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            out_wait <= 0;
        end else if (o_valid && i_ready) begin
            w = $urandom_range(0, 13);
            out_wait <= w;
            i_ready  <= (w == 0);
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            i_ready  <= (out_wait == 1);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** error_function_approx_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [31:0] directed[$];
        directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h1000_0000, 32'hF000_0000, 32'h1000_0001, 32'hEFFF_FFFF,
                     32'h0FFF_FFFF, 32'h0400_0000, 32'hFC00_0000, 32'h0800_0000,
                     32'h0C00_0000, 32'h0010_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h0000_FFFF, 32'h0E00_0000};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) send_word(directed[i], 1'b0);
        for (int i = 0; i < 1350; i++) begin
            if (i == 600) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
                @(posedge i_clk);
            end
            send_word(random_arg(), (i > 900 && i < 1100));
        end
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) $display("** error_function_approx_unit: PASSED **");
        else $display("** error_function_approx_unit: FAILED **");
        $finish;
    end
endmodule

FILE: files.f
rtl/erfa_pkg.sv
rtl/erfa_div_cell.sv
rtl/erfa_mul.sv
rtl/erfa_poly_cell.sv
rtl/erfa_exp_cell.sv
rtl/error_function_approx_unit.sv
dv/error_function_approx_checker.sv
dv/error_function_approx_unit_test.sv
